// ----- hdl/nfba_pkg.sv -----
// Shared types and constants for the next-fit block allocator.
// No dependencies; imported by the sequencer, top level, checker and testbench.
`default_nettype none

package nfba_pkg;

    // Field widths of the channels and configuration registers
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int OFFSET_W   = 22;
    localparam int COUNT_W    = 7;
    localparam int BYTES_W    = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;

    // Defaults and limits
    localparam int MAX_BLOCKS_DEF      = 64;
    localparam int BLOCK_COUNT_RESET   = 64;
    localparam int BLOCK_BYTES_RESET   = 1024;
    localparam int MAX_BLOCK_BYTES     = 65536;

    // Request mode
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BYTES = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        STS_GRANTED   = 2'd0,
        STS_NONE_FREE = 2'd1,
        STS_RELEASED  = 2'd2,
        STS_BAD_REL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_GRANT,
        SEQ_REL_RD,
        SEQ_REL_CHK,
        SEQ_DONE
    } seq_state_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0] block_count;
        logic [BYTES_W-1:0] block_bytes;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/nfba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nfba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/nfba_wrap_inc.sv -----
// Circular pointer step: index plus one, wrapping to zero at the pool size.
// Depends on nothing but its parameter; shared by the scan and pointer update.
`default_nettype none

module nfba_wrap_inc #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic [$clog2(MAX_BLOCKS)-1:0]   pos,
    input  wire logic [$clog2(MAX_BLOCKS+1)-1:0] pool_n,
    output logic      [$clog2(MAX_BLOCKS)-1:0]   pos_next
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [CW-1:0] inc;

    // Add one, compare against the pool size, wrap
    always_comb begin
        inc      = CW'(pos) + CW'(1);
        pos_next = (inc < pool_n) ? IW'(inc) : '0;
    end

endmodule

`default_nettype wire

// ----- hdl/nfba_seq.sv -----
// Allocator sequencer: flag store clear, circular scan, grant and release.
// Depends on nfba_pkg, nfba_ram and nfba_wrap_inc.
`default_nettype none

module nfba_seq #(
    parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire nfba_pkg::cfg_t                cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [nfba_pkg::INDEX_W-1:0]  s_release_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [nfba_pkg::STATUS_W-1:0]      m_status,
    output logic [nfba_pkg::INDEX_W-1:0]       m_granted_index,
    output logic [nfba_pkg::OFFSET_W-1:0]      m_granted_offset,
    output logic [nfba_pkg::COUNT_W-1:0]       m_used_count
);

    import nfba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = IW + BYTES_W;

    seq_state_t state_reg, state_next;

    logic [IW-1:0]       clr_addr_reg, clr_addr_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic [IW-1:0]       chk_reg, chk_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [IW-1:0]       rel_reg, rel_next;
    logic [IW-1:0]       next_slot_reg, next_slot_next;
    logic [CW-1:0]       busy_reg, busy_next;
    status_t             res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [OFFSET_W-1:0] m_offset_reg, m_offset_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic          ram_rdata;

    logic [IW-1:0] wrap_in;
    logic [IW-1:0] wrap_out;

    logic [CW-1:0]      pool_n;
    logic [IW-1:0]      start_pos;
    logic [BYTES_W-1:0] bb_clamp;
    logic [PW-1:0]      product;

    nfba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_flags (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nfba_wrap_inc #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_wrap (
        .pos      (wrap_in),
        .pool_n   (n_reg),
        .pos_next (wrap_out)
    );

    // Effective pool size, scan start and clamped block size
    always_comb begin
        if (cfg.block_count == '0) begin
            pool_n = CW'(1);
        end else if (int'(cfg.block_count) > MAX_BLOCKS) begin
            pool_n = CW'(MAX_BLOCKS);
        end else begin
            pool_n = CW'(cfg.block_count);
        end
        start_pos = (CW'(next_slot_reg) < pool_n) ? next_slot_reg : '0;
        bb_clamp  = (int'(cfg.block_bytes) > MAX_BLOCK_BYTES) ?
                    BYTES_W'(MAX_BLOCK_BYTES) : cfg.block_bytes;
        product   = PW'(chk_reg) * PW'(bb_clamp);
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            next_slot_reg <= '0;
            busy_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            clr_addr_reg  <= clr_addr_next;
            chk_vld_reg   <= chk_vld_next;
            next_slot_reg <= next_slot_next;
            busy_reg      <= busy_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        chk_reg        <= chk_next;
        cnt_reg        <= cnt_next;
        n_reg          <= n_next;
        rel_reg        <= rel_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_offset_reg <= res_offset_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_offset_reg   <= m_offset_next;
        m_count_reg    <= m_count_next;
    end

    // Next state, store access and datapath updates
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        addr_next       = addr_reg;
        chk_next        = chk_reg;
        chk_vld_next    = chk_vld_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        rel_next        = rel_reg;
        next_slot_next  = next_slot_reg;
        busy_next       = busy_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_offset_next = res_offset_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_offset_next   = m_offset_reg;
        m_count_next    = m_count_reg;
        m_valid_next    = m_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = 1'b0;
        ram_raddr = addr_reg;
        wrap_in   = addr_reg;
        s_ready   = 1'b0;

        // Drop the output transaction once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_CLEAR: begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + IW'(1);
                if (clr_addr_reg == IW'(MAX_BLOCKS - 1)) begin
                    state_next = SEQ_IDLE;
                end
            end

            SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_index_next  = '0;
                    res_offset_next = '0;
                    if (s_mode == MODE_ALLOC) begin
                        addr_next    = start_pos;
                        chk_vld_next = 1'b0;
                        cnt_next     = '0;
                        n_next       = pool_n;
                        state_next   = SEQ_SCAN;
                    end else if (int'(s_release_index) < MAX_BLOCKS) begin
                        rel_next   = IW'(s_release_index);
                        state_next = SEQ_REL_RD;
                    end else begin
                        res_status_next = STS_BAD_REL;
                        state_next      = SEQ_DONE;
                    end
                end
            end

            SEQ_SCAN: begin
                // Issue one flag read per cycle, check the one issued before
                if (chk_vld_reg && !ram_rdata) begin
                    state_next = SEQ_GRANT;
                end else if (chk_vld_reg && (cnt_reg + CW'(1) == n_reg)) begin
                    res_status_next = STS_NONE_FREE;
                    state_next      = SEQ_DONE;
                end else begin
                    chk_next     = addr_reg;
                    chk_vld_next = 1'b1;
                    addr_next    = wrap_out;
                    if (chk_vld_reg) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end

            SEQ_GRANT: begin
                ram_we          = 1'b1;
                ram_waddr       = chk_reg;
                ram_wdata       = 1'b1;
                wrap_in         = chk_reg;
                next_slot_next  = wrap_out;
                busy_next       = busy_reg + CW'(1);
                res_status_next = STS_GRANTED;
                res_index_next  = INDEX_W'(chk_reg);
                res_offset_next = OFFSET_W'(product);
                state_next      = SEQ_DONE;
            end

            SEQ_REL_RD: begin
                ram_raddr  = rel_reg;
                state_next = SEQ_REL_CHK;
            end

            SEQ_REL_CHK: begin
                if (ram_rdata) begin
                    ram_we          = 1'b1;
                    ram_waddr       = rel_reg;
                    ram_wdata       = 1'b0;
                    if (busy_reg != '0) begin
                        busy_next = busy_reg - CW'(1);
                    end
                    res_status_next = STS_RELEASED;
                end else begin
                    res_status_next = STS_BAD_REL;
                end
                state_next = SEQ_DONE;
            end

            SEQ_DONE: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_offset_next = res_offset_reg;
                    m_count_next  = COUNT_W'(busy_reg);
                    state_next    = SEQ_IDLE;
                end
            end

            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_index  = m_index_reg;
    assign m_granted_offset = m_offset_reg;
    assign m_used_count     = m_count_reg;

endmodule

`default_nettype wire

// ----- hdl/next_fit_block_allocator_unit.sv -----
// Next-fit block allocator top level: configuration registers and sequencer.
// Depends on nfba_pkg and nfba_seq.
//
// Usage:
//   Input channel (s_valid/s_ready): s_mode 0 allocates a block, 1 releases
//   s_release_index. Result channel (m_valid/m_ready): one transaction per
//   request with status, granted index, byte offset and the in-use count.
//   Configuration: cfg_we writes cfg_wdata to block_count (index 0) or
//   block_bytes (index 1) as a registered write; write only while idle.
// Timing:
//   One request at a time. An allocation scans the flag RAM one block per
//   cycle (registered read) from the next-fit pointer, probing at most the
//   pool size of blocks. A release reads the flag, then checks and clears it;
//   an out-of-range release goes straight to the result.
// Reset:
//   aresetn low clears pointer, in-use count and output valid; after
//   it, a clearing pass over all MAX_BLOCKS flags zeroes the flag RAM while
//   s_ready stays low. Configuration returns to 64 blocks of 1024 bytes.
// Stall:
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and its result waits until the register is free.
`default_nettype none

module next_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [nfba_pkg::INDEX_W-1:0]    s_release_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [nfba_pkg::STATUS_W-1:0]        m_status,
    output logic [nfba_pkg::INDEX_W-1:0]         m_granted_index,
    output logic [nfba_pkg::OFFSET_W-1:0]        m_granted_offset,
    output logic [nfba_pkg::COUNT_W-1:0]         m_used_count,
    input  wire logic                            cfg_we,
    input  wire logic [nfba_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [nfba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import nfba_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // Configuration write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_BLOCK_COUNT: cfg_next.block_count = cfg_wdata[COUNT_W-1:0];
                REG_BLOCK_BYTES: cfg_next.block_bytes = cfg_wdata[BYTES_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_count <= COUNT_W'(BLOCK_COUNT_RESET);
            cfg_reg.block_bytes <= BYTES_W'(BLOCK_BYTES_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nfba_seq #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_release_index  (s_release_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_index  (m_granted_index),
        .m_granted_offset (m_granted_offset),
        .m_used_count     (m_used_count)
    );

endmodule

`default_nettype wire

// ----- hdl/nfba_checker.sv -----
// Port-level checks for the next-fit block allocator, bound to the top level.
// Depends on nfba_pkg and next_fit_block_allocator_unit.
`default_nettype none

module nfba_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [nfba_pkg::STATUS_W-1:0]   m_status,
    input wire logic [nfba_pkg::INDEX_W-1:0]    m_granted_index,
    input wire logic [nfba_pkg::OFFSET_W-1:0]   m_granted_offset,
    input wire logic [nfba_pkg::COUNT_W-1:0]    m_used_count
);

    import nfba_pkg::*;

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_granted_index) && $stable(m_granted_offset) && $stable(m_used_count))
        else $error("stalled result changed");

    // One request at a time: busy right after an accepted transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a request while one is in progress");

    // Only a grant carries an index and offset
    a_zero_unless_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STS_GRANTED) |->
        (m_granted_index == '0) && (m_granted_offset == '0))
        else $error("non-grant result carries index or offset");

    // A grant reports a nonzero in-use count
    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_GRANTED) |-> (m_used_count != '0))
        else $error("grant reported with zero blocks in use");

endmodule

bind next_fit_block_allocator_unit nfba_checker u_nfba_checker (.*);

`default_nettype wire

// ----- tb/tb_next_fit_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for next_fit_block_allocator_unit: directed table, then random phases.
// Depends on nfba_pkg and the allocator RTL; predicts each result with its own pool model or a fixed table entry.

module tb_next_fit_block_allocator_unit;

    import nfba_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int LONG_HOLD       = 160;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 70;

    typedef struct {
        status_t              status;
        logic [INDEX_W-1:0]   index;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   used;
    } result_t;

    // Optional hand-written expectation that overrides the pool model
    typedef struct {
        bit      fixed;
        result_t res;
    } typed_entry_t;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic                    mode;
        logic [INDEX_W-1:0]      idx;
        logic [CFG_ADDR_W-1:0]   reg_sel;
        logic [CFG_DATA_W-1:0]   value;
        bit                      fixed;
        result_t                 res;
    } plan_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_mode;
    logic [INDEX_W-1:0]      s_release_index;
    logic                    m_valid;
    logic                    m_ready;
    logic [STATUS_W-1:0]     m_status;
    logic [INDEX_W-1:0]      m_granted_index;
    logic [OFFSET_W-1:0]     m_granted_offset;
    logic [COUNT_W-1:0]      m_used_count;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    // Pool model: flags, next-fit pointer, in-use total and register copies
    bit                      blk_busy [MAX_BLOCKS_DEF];
    int                      scan_ptr = 0;
    int                      busy_blocks = 0;
    logic [COUNT_W-1:0]      pool_blocks_reg = COUNT_W'(BLOCK_COUNT_RESET);
    logic [BYTES_W-1:0]      pool_bytes_reg = BYTES_W'(BLOCK_BYTES_RESET);

    result_t                 pending_results [$];
    typed_entry_t            typed_results [$];
    int                      sent_cnt = 0;
    int                      done_cnt = 0;
    int                      err_cnt = 0;
    int                      cycle_cnt = 0;
    int                      status_hits [4] = '{0, 0, 0, 0};
    bit                      hold_req = 1'b0;
    bit                      quiet = 1'b0;

    next_fit_block_allocator_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_release_index  (s_release_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_index  (m_granted_index),
        .m_granted_offset (m_granted_offset),
        .m_used_count     (m_used_count),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Next-fit allocation or release on the pool model; returns the expected transaction
    function automatic result_t allocate_or_release(logic mode, logic [INDEX_W-1:0] idx);
        result_t r;
        int      n;
        int      pos;
        int      bb;
        bit      found;
        r.status = STS_BAD_REL;
        r.index  = '0;
        r.offset = '0;
        found    = 1'b0;
        if (mode == MODE_ALLOC) begin
            n = pool_blocks_reg;
            if (n == 0) n = 1;
            if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
            pos = (scan_ptr < n) ? scan_ptr : 0;
            r.status = STS_NONE_FREE;
            for (int k = 0; k < n && !found; k++) begin
                if (!blk_busy[pos]) begin
                    bb = (pool_bytes_reg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : pool_bytes_reg;
                    blk_busy[pos] = 1'b1;
                    busy_blocks++;
                    r.index  = INDEX_W'(pos);
                    r.offset = OFFSET_W'(pos * bb);
                    scan_ptr = (pos + 1 < n) ? pos + 1 : 0;
                    r.status = STS_GRANTED;
                    found    = 1'b1;
                end else begin
                    pos = (pos + 1 < n) ? pos + 1 : 0;
                end
            end
        end else if (blk_busy[idx]) begin
            blk_busy[idx] = 1'b0;
            if (busy_blocks > 0) busy_blocks--;
            r.status = STS_RELEASED;
        end
        r.used = COUNT_W'(busy_blocks);
        return r;
    endfunction

    // Table row builders
    function automatic plan_row_t req(logic mode, logic [INDEX_W-1:0] idx);
        plan_row_t p;
        p.kind    = ROW_REQ;
        p.mode    = mode;
        p.idx     = idx;
        p.reg_sel = REG_BLOCK_COUNT;
        p.value   = '0;
        p.fixed   = 1'b0;
        return p;
    endfunction

    function automatic plan_row_t req_fixed(logic mode, logic [INDEX_W-1:0] idx, status_t st,
                                            int gidx, int goff, int used);
        plan_row_t p;
        p = req(mode, idx);
        p.fixed      = 1'b1;
        p.res.status = st;
        p.res.index  = INDEX_W'(gidx);
        p.res.offset = OFFSET_W'(goff);
        p.res.used   = COUNT_W'(used);
        return p;
    endfunction

    function automatic plan_row_t reg_write(logic [CFG_ADDR_W-1:0] sel, int value);
        plan_row_t p;
        p = req(MODE_ALLOC, '0);
        p.kind    = ROW_CFG;
        p.reg_sel = sel;
        p.value   = CFG_DATA_W'(value);
        return p;
    endfunction

    // Offer one request and hold it until it is accepted
    task automatic send_request(logic mode, logic [INDEX_W-1:0] idx, bit fixed, result_t res);
        typed_entry_t t;
        t.fixed = fixed;
        t.res   = res;
        // release the write strobe of any preceding register write
        cfg_we <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        typed_results = {typed_results, t};
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_release_index <= idx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sent_cnt++;
    endtask

    // Drop valid and wait until every request has produced its result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (done_cnt < sent_cnt) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Track register writes, check results and predict accepted requests
    always @(posedge aclk) begin : scoreboard
        result_t      want;
        typed_entry_t typed;
        if (cfg_we === 1'b1) begin
            if (cfg_addr == REG_BLOCK_COUNT)
                pool_blocks_reg = cfg_wdata[COUNT_W-1:0];
            else
                pool_bytes_reg = cfg_wdata[BYTES_W-1:0];
        end
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            done_cnt++;
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result transaction with nothing expected (status %0d)",
                         $realtime, m_status);
            end else begin
                want = pending_results.pop_front();
                if ({m_status, m_granted_index, m_granted_offset, m_used_count} !==
                    {want.status, want.index, want.offset, want.used}) begin
                    err_cnt++;
                    $display("%0t: mismatch: expected status %0d index %0d offset %0d used %0d",
                             $realtime, want.status, want.index, want.offset, want.used);
                    $display("%0t:           actual status %0d index %0d offset %0d used %0d",
                             $realtime, m_status, m_granted_index, m_granted_offset,
                             m_used_count);
                end
            end
        end
        if (s_valid === 1'b1 && s_ready === 1'b1) begin
            typed = typed_results.pop_front();
            want  = allocate_or_release(s_mode, s_release_index);
            if (typed.fixed) want = typed.res;
            status_hits[want.status]++;
            pending_results = {pending_results, want};
        end
    end

    // Result side: random stalls, one long hold-off on request, none when quiet
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        plan_row_t plan [$];
        result_t   no_result;
        int        phase_blocks [N_PHASES];
        int        phase_bytes [N_PHASES];
        int        alloc_pct [N_PHASES];
        int        busy_list [$];
        int        cnt;
        int        bytes;
        int        rel;

        phase_blocks = '{64, 1, 127, 0, -1, 2, 64, -1, 33};
        phase_bytes  = '{65536, 131071, 1, 0, -1, 1024, -1, 65535, -1};
        alloc_pct    = '{85, 60, 40, 90, 50, 70, 95, 30, 55};

        s_valid         <= 1'b0;
        s_mode          <= MODE_ALLOC;
        s_release_index <= '0;
        cfg_we          <= 1'b0;
        cfg_addr        <= REG_BLOCK_COUNT;
        cfg_wdata       <= '0;
        aresetn         <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset configuration first: 64 blocks of 1024 bytes
        plan = {plan, req_fixed(MODE_ALLOC,   6'd0,  STS_GRANTED,   0, 0,    1)};
        plan = {plan, req_fixed(MODE_ALLOC,   6'd63, STS_GRANTED,   1, 1024, 2)};
        plan = {plan, req_fixed(MODE_RELEASE, 6'd63, STS_BAD_REL,   0, 0,    2)};
        plan = {plan, req_fixed(MODE_RELEASE, 6'd1,  STS_RELEASED,  0, 0,    1)};
        plan = {plan, req_fixed(MODE_RELEASE, 6'd1,  STS_BAD_REL,   0, 0,    1)};
        // oversized block: offset uses the clamped size
        plan = {plan, reg_write(REG_BLOCK_BYTES, 131071)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, reg_write(REG_BLOCK_BYTES, 0)};
        plan = {plan, req_fixed(MODE_ALLOC,   6'd0,  STS_GRANTED,   3, 0,    3)};
        // zero block count acts as one; pointer lies beyond that pool
        plan = {plan, reg_write(REG_BLOCK_COUNT, 0)};
        plan = {plan, req_fixed(MODE_ALLOC,   6'd0,  STS_NONE_FREE, 0, 0,    3)};
        plan = {plan, req(MODE_RELEASE, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        // release of a block outside the shrunken pool
        plan = {plan, req(MODE_RELEASE, 6'd3)};
        plan = {plan, reg_write(REG_BLOCK_COUNT, 127)};
        plan = {plan, reg_write(REG_BLOCK_BYTES, 1)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, reg_write(REG_BLOCK_COUNT, 2)};
        plan = {plan, reg_write(REG_BLOCK_BYTES, 65536)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_RELEASE, 6'd1)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, reg_write(REG_BLOCK_COUNT, 64)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_RELEASE, 6'd2)};
        plan = {plan, reg_write(REG_BLOCK_COUNT, 1)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};
        plan = {plan, req(MODE_RELEASE, 6'd0)};
        plan = {plan, req(MODE_ALLOC, 6'd0)};

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[r].reg_sel, plan[r].value);
            end else begin
                send_request(plan[r].mode, plan[r].idx, plan[r].fixed, plan[r].res);
            end
        end

        // Random phases: new pool settings each time, pool contents carried over
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            cnt   = (phase_blocks[p] < 0) ? $urandom_range(0, 127) : phase_blocks[p];
            bytes = (phase_bytes[p] < 0) ? $urandom_range(0, 131071) : phase_bytes[p];
            write_reg(REG_BLOCK_COUNT, {10'($urandom), 7'(cnt)});
            write_reg(REG_BLOCK_BYTES, 17'(bytes));
            if (p == N_PHASES - 1) quiet = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 2 && i == 20) hold_req = 1'b1;
                if ($urandom_range(0, 99) < alloc_pct[p]) begin
                    send_request(MODE_ALLOC, 6'($urandom), 1'b0, no_result);
                end else begin
                    // mostly free a block that is held, sometimes any index
                    busy_list.delete();
                    foreach (blk_busy[b]) if (blk_busy[b]) busy_list = {busy_list, b};
                    if (busy_list.size() != 0 && $urandom_range(0, 3) != 0)
                        rel = busy_list[$urandom_range(0, busy_list.size() - 1)];
                    else
                        rel = $urandom_range(0, 63);
                    send_request(MODE_RELEASE, 6'(rel), 1'b0, no_result);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d requests over %0d pool settings: %0d grants, %0d pool-full refusals,",
                 sent_cnt, N_PHASES + 1, status_hits[STS_GRANTED], status_hits[STS_NONE_FREE]);
        $display("%0d releases and %0d refused releases; %0d mismatches.",
                 status_hits[STS_RELEASED], status_hits[STS_BAD_REL], err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
